// ===== design/bfpl_pkg.sv =====
// shared constants and types for the per-label boundary fraction block
package bfpl_pkg;

	localparam int COUNT_BITS = 32;
	localparam int NUM_LABELS = 4096;
	localparam int LABEL_BITS = $clog2(NUM_LABELS);
	localparam int FRAC_BITS  = 16;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int STEP_BITS  = $clog2(QUO_BITS + 1);
	localparam int WORD_BITS  = 2 * COUNT_BITS;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic {
		ST_CLEAR = 1'b0,
		ST_RUN   = 1'b1
	} st_t;

	typedef struct packed {
		logic [LABEL_BITS-1:0] label;
		logic [QUO_BITS-1:0]   fraction;
		logic                  empty;
	} div_res_t;

	typedef struct packed {
		logic                  start;
		logic                  empty;
		logic [LABEL_BITS-1:0] label;
	} div_cmd_t;

endpackage

// ===== design/bfpl_if.sv =====
// valid/ready channels for cell items and fraction results
interface bfpl_cell_if;
	logic                            valid;
	logic                            ready;
	bfpl_pkg::op_t                   opcode;
	logic [bfpl_pkg::LABEL_BITS-1:0] feature_label;
	logic signed [7:0]               neighbour_diff_count;

	modport source (output valid, opcode, feature_label, neighbour_diff_count, input ready);
	modport sink (input valid, opcode, feature_label, neighbour_diff_count, output ready);
endinterface

interface bfpl_res_if;
	logic                            valid;
	logic                            ready;
	logic [bfpl_pkg::LABEL_BITS-1:0] label_out;
	logic [bfpl_pkg::QUO_BITS-1:0]   fraction;
	logic                            empty_label;

	modport source (output valid, label_out, fraction, empty_label, input ready);
	modport sink (input valid, label_out, fraction, empty_label, output ready);
endinterface

// ===== design/boundary_fraction_per_label.sv =====
// adds: one per cycle while cells.ready is high (no read in stage 1 or divider, no sweep), counters updated in the
// cycle after the transfer (forwarded to a following item); reads: result passes stage 1, the divider and the output
// register, one bit per divider step (an empty label skips the steps); no item is taken while a read is in the
// divider, so reads run one at a time; reset and a clear item start a zeroing sweep over all 4096 counter ram words,
// no items taken meanwhile; results stay in the output register until transferred; adds keep flowing behind them
module boundary_fraction_per_label (
	input  logic         clk,
	input  logic         arst_n,
	bfpl_cell_if.sink    cells,
	bfpl_res_if.source   results
);

	localparam logic [bfpl_pkg::COUNT_BITS-1:0] CNT_MAX = '1;

	bfpl_pkg::st_t                       state_q, state_d;
	logic [bfpl_pkg::LABEL_BITS-1:0]     sweep_q;
	logic                                sweep_end;

	logic                                cell_xfer;
	logic                                s1_valid;
	bfpl_pkg::op_t                       op_s1;
	logic [bfpl_pkg::LABEL_BITS-1:0]     label_s1;
	logic                                bnd_s1;

	logic [bfpl_pkg::WORD_BITS-1:0]      rd_word;
	logic [bfpl_pkg::WORD_BITS-1:0]      cur_word;
	logic [bfpl_pkg::COUNT_BITS-1:0]     cur_cells, cur_bnd, new_cells, new_bnd;

	logic                                fwd_valid_q;
	logic [bfpl_pkg::LABEL_BITS-1:0]     fwd_addr_q;
	logic [bfpl_pkg::WORD_BITS-1:0]      fwd_data_q;

	logic                                we;
	logic [bfpl_pkg::LABEL_BITS-1:0]     waddr;
	logic [bfpl_pkg::WORD_BITS-1:0]      wdata;
	logic                                upd_we;

	bfpl_pkg::div_cmd_t                  div_cmd;
	bfpl_pkg::div_res_t                  div_res;
	logic                                div_busy, div_valid, div_take;

	logic                                out_valid_q;
	bfpl_pkg::div_res_t                  out_q;

	// ---------------- control ----------------
	assign sweep_end = (sweep_q == bfpl_pkg::LABEL_BITS'(bfpl_pkg::NUM_LABELS - 1));

	assign cells.ready = (state_q == bfpl_pkg::ST_RUN) && !div_busy
		&& !(s1_valid && op_s1 == bfpl_pkg::OP_READ);
	assign cell_xfer = cells.valid && cells.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfpl_pkg::ST_CLEAR: begin
				if (sweep_end) begin
					state_d = bfpl_pkg::ST_RUN;
				end
			end
			bfpl_pkg::ST_RUN: begin
				if (cell_xfer && cells.opcode == bfpl_pkg::OP_CLEAR) begin
					state_d = bfpl_pkg::ST_CLEAR;
				end
			end
			default: state_d = bfpl_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfpl_pkg::ST_CLEAR;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bfpl_pkg::ST_CLEAR) begin
				sweep_q <= sweep_q + bfpl_pkg::LABEL_BITS'(1);
			end else begin
				sweep_q <= '0;
			end
		end
	end

	// ---------------- stage 1: ram read data arrives ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= cell_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_xfer) begin
			op_s1    <= cells.opcode;
			label_s1 <= cells.feature_label;
			bnd_s1   <= !cells.neighbour_diff_count[7] && (cells.neighbour_diff_count != 8'sd0);
		end
	end

	bfpl_ram #(
		.WIDTH(bfpl_pkg::WORD_BITS),
		.DEPTH(bfpl_pkg::NUM_LABELS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (cells.feature_label),
		.rdata (rd_word)
	);

	// the write of the previous cycle is not yet visible in the read data
	always_comb begin
		cur_word  = (fwd_valid_q && fwd_addr_q == label_s1) ? fwd_data_q : rd_word;
		cur_cells = cur_word[bfpl_pkg::COUNT_BITS-1:0];
		cur_bnd   = cur_word[bfpl_pkg::WORD_BITS-1:bfpl_pkg::COUNT_BITS];
		new_cells = (cur_cells == CNT_MAX) ? cur_cells : cur_cells + bfpl_pkg::COUNT_BITS'(1);
		new_bnd   = (bnd_s1 && cur_bnd != CNT_MAX) ? cur_bnd + bfpl_pkg::COUNT_BITS'(1) : cur_bnd;
		upd_we    = s1_valid && op_s1 == bfpl_pkg::OP_ADD;
	end

	always_comb begin
		if (state_q == bfpl_pkg::ST_CLEAR) begin
			we    = 1'b1;
			waddr = sweep_q;
			wdata = '0;
		end else begin
			we    = upd_we;
			waddr = label_s1;
			wdata = {new_bnd, new_cells};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= (state_q == bfpl_pkg::ST_RUN) && upd_we;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_we) begin
			fwd_addr_q <= label_s1;
			fwd_data_q <= wdata;
		end
	end

	// ---------------- read: divider and result register ----------------
	always_comb begin
		div_cmd.start = s1_valid && op_s1 == bfpl_pkg::OP_READ;
		div_cmd.label = label_s1;
		div_cmd.empty = (label_s1 == '0) || (cur_cells == '0);
	end

	bfpl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (div_cmd),
		.num       (cur_bnd),
		.den       (cur_cells),
		.take      (div_take),
		.busy      (div_busy),
		.res_valid (div_valid),
		.res       (div_res)
	);

	assign div_take = div_valid && (!out_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_take) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_take) begin
			out_q <= div_res;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.label_out   = out_q.label;
	assign results.fraction    = out_q.fraction;
	assign results.empty_label = out_q.empty;

endmodule

// ===== design/bfpl_ram.sv =====
// generic single-write, single-read ram with registered read data
module bfpl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/bfpl_div.sv =====
// restoring divider, one quotient bit per cycle: floor(num * 2^16 / den)
module bfpl_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bfpl_pkg::div_cmd_t              cmd,
	input  logic [bfpl_pkg::COUNT_BITS-1:0] num,
	input  logic [bfpl_pkg::COUNT_BITS-1:0] den,
	input  logic                            take,
	output logic                            busy,
	output logic                            res_valid,
	output bfpl_pkg::div_res_t              res
);

	logic                                  run_q;
	logic                                  done_q;
	logic                                  shift_q;
	logic [bfpl_pkg::STEP_BITS-1:0]        cnt_q;
	logic [bfpl_pkg::COUNT_BITS:0]         rem_q;
	logic [bfpl_pkg::COUNT_BITS-1:0]       den_q;
	logic [bfpl_pkg::QUO_BITS-1:0]         quo_q;
	logic [bfpl_pkg::LABEL_BITS-1:0]       label_q;
	logic                                  empty_q;
	logic [bfpl_pkg::COUNT_BITS:0]         trial;
	logic [bfpl_pkg::COUNT_BITS:0]         den_ext;
	logic                                  fits;

	always_comb begin
		trial   = shift_q ? {rem_q[bfpl_pkg::COUNT_BITS-1:0], 1'b0} : rem_q;
		den_ext = {1'b0, den_q};
		fits    = (trial >= den_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (cmd.start) begin
			run_q  <= !cmd.empty;
			done_q <= cmd.empty;
		end else if (run_q && cnt_q == bfpl_pkg::STEP_BITS'(1)) begin
			run_q  <= 1'b0;
			done_q <= 1'b1;
		end else if (done_q && take) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q   <= {1'b0, num};
			den_q   <= den;
			quo_q   <= '0;
			shift_q <= 1'b0;
			cnt_q   <= bfpl_pkg::STEP_BITS'(bfpl_pkg::QUO_BITS);
			label_q <= cmd.label;
			empty_q <= cmd.empty;
		end else if (run_q) begin
			rem_q   <= fits ? (trial - den_ext) : trial;
			quo_q   <= {quo_q[bfpl_pkg::QUO_BITS-2:0], fits};
			shift_q <= 1'b1;
			cnt_q   <= cnt_q - bfpl_pkg::STEP_BITS'(1);
		end
	end

	assign busy         = run_q || done_q;
	assign res_valid    = done_q;
	assign res.label    = label_q;
	assign res.fraction = empty_q ? '0 : quo_q;
	assign res.empty    = empty_q;

endmodule

// ===== bench/tb_top.sv =====
// testbench for boundary_fraction_per_label: cell stream driver, fraction checker
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bfpl_pkg::*;

	typedef struct {
		op_t                   op;
		logic [LABEL_BITS-1:0] lbl;
		logic signed [7:0]     nd;
		bit                    hold;
	} cell_item_t;

	typedef struct {
		logic [LABEL_BITS-1:0] lbl;
		logic [QUO_BITS-1:0]   frac;
		logic                  empty;
		longint                stamp;
	} fraction_exp_t;

	logic clk = 1'b0;
	logic arst_n;

	bfpl_cell_if cells_ch ();
	bfpl_res_if  res_ch ();

	boundary_fraction_per_label uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cells   (cells_ch),
		.results (res_ch)
	);

	always #5ns clk = ~clk;

	// per-label tallies kept by the bench
	logic [COUNT_BITS-1:0] cells_seen   [NUM_LABELS];
	logic [COUNT_BITS-1:0] border_cells [NUM_LABELS];

	cell_item_t    stim_q [$];
	fraction_exp_t fraction_due [$];

	int     mismatches = 0;
	longint cyc = 0;
	int     burst_left = 0;
	int     gap_left = 0;
	int     stall_mode = 0;
	int     stall_left = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void clear_tallies();
		foreach (cells_seen[i]) begin
			cells_seen[i]   = '0;
			border_cells[i] = '0;
		end
	endfunction

	// applies one accepted cell item, returns 1 when it yields a fraction result
	function automatic bit predict_item(input op_t op, input logic [LABEL_BITS-1:0] lbl,
			input logic signed [7:0] nd, output fraction_exp_t res);
		logic [COUNT_BITS+FRAC_BITS-1:0] num;
		logic [COUNT_BITS+FRAC_BITS-1:0] quo;
		int idx;
		idx = int'(lbl);
		res = '{lbl: lbl, frac: '0, empty: 1'b1, stamp: 0};
		case (op)
			OP_ADD: begin
				if (idx < NUM_LABELS) begin
					if (cells_seen[idx] != '1)
						cells_seen[idx]++;
					if (nd > 0 && border_cells[idx] != '1)
						border_cells[idx]++;
				end
				return 1'b0;
			end
			OP_CLEAR: begin
				clear_tallies();
				return 1'b0;
			end
			OP_READ: begin
				// label zero is counted but always reads as empty
				if (idx != 0 && idx < NUM_LABELS && cells_seen[idx] != '0) begin
					num = {border_cells[idx], FRAC_BITS'(0)};
					quo = num / cells_seen[idx];
					if (quo > (1 << FRAC_BITS))
						quo = 1 << FRAC_BITS;
					res.frac  = quo[QUO_BITS-1:0];
					res.empty = 1'b0;
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic push_item(input op_t op, input int lbl, input int nd, input bit hold);
		stim_q = {stim_q, cell_item_t'{op: op, lbl: LABEL_BITS'(lbl), nd: 8'(nd), hold: hold}};
	endtask

	// sender: bursts with random gaps, items taken from stim_q
	always @(posedge clk) begin
		cell_item_t    item;
		fraction_exp_t due;
		if (arst_n) begin
			if (cells_ch.valid && cells_ch.ready) begin
				if (predict_item(cells_ch.opcode, cells_ch.feature_label,
						cells_ch.neighbour_diff_count, due)) begin
					due.stamp = cyc;
					fraction_due = {fraction_due, due};
				end
			end
			if (!cells_ch.valid || cells_ch.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					cells_ch.valid <= 1'b0;
				end else if (stim_q.size() != 0 &&
						!(stim_q[0].hold && fraction_due.size() != 0)) begin
					item = stim_q.pop_front();
					cells_ch.valid                <= 1'b1;
					cells_ch.opcode               <= item.op;
					cells_ch.feature_label        <= item.lbl;
					cells_ch.neighbour_diff_count <= item.nd;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					cells_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result transfer and stalls in changing modes
	always @(posedge clk) begin
		fraction_exp_t want;
		cyc <= cyc + 1;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				// an expectation stamped this cycle cannot have a result yet
				if (fraction_due.size() == 0 || fraction_due[0].stamp == cyc) begin
					report_mismatch($sformatf("result with none expected, label %0d",
						res_ch.label_out));
				end else begin
					want = fraction_due.pop_front();
					if (res_ch.label_out !== want.lbl)
						report_mismatch($sformatf("label_out %0d, wanted %0d",
							res_ch.label_out, want.lbl));
					if (res_ch.fraction !== want.frac)
						report_mismatch($sformatf("fraction %0d, wanted %0d (label %0d)",
							res_ch.fraction, want.frac, want.lbl));
					if (res_ch.empty_label !== want.empty)
						report_mismatch($sformatf("empty_label %0b, wanted %0b (label %0d)",
							res_ch.empty_label, want.empty, want.lbl));
				end
			end
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_left <= $urandom_range(20, 300);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= ($urandom_range(0, 3) != 0);
				2: res_ch.ready <= ($urandom_range(0, 3) == 0);
				default: res_ch.ready <= ((cyc % 24) >= 16);
			endcase
		end
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [LABEL_BITS-1:0] pool [8];
		int bias [8];
		int n;
		int pool_age;
		int clears;
		int r;
		int slot;
		int lbl;
		int nd;
		bit first;

		arst_n                        = 1'b0;
		cells_ch.valid                = 1'b0;
		cells_ch.opcode               = OP_NOP;
		cells_ch.feature_label        = '0;
		cells_ch.neighbour_diff_count = '0;
		res_ch.ready                  = 1'b0;
		clear_tallies();

		// directed: empty reads, label zero, all-boundary, no-boundary, thirds, unused op, clear
		push_item(OP_READ, 0, 0, 1'b0);
		push_item(OP_READ, 4095, 0, 1'b0);
		push_item(OP_ADD, 0, 5, 1'b0);
		push_item(OP_READ, 0, 0, 1'b0);
		push_item(OP_ADD, 4095, 127, 1'b0);
		push_item(OP_ADD, 4095, -128, 1'b0);
		push_item(OP_ADD, 4095, 0, 1'b0);
		push_item(OP_ADD, 4095, 1, 1'b0);
		push_item(OP_READ, 4095, 0, 1'b0);
		push_item(OP_ADD, 1, 127, 1'b0);
		push_item(OP_READ, 1, 0, 1'b0);
		push_item(OP_ADD, 2, -1, 1'b0);
		push_item(OP_READ, 2, 0, 1'b0);
		push_item(OP_ADD, 3, 1, 1'b0);
		push_item(OP_ADD, 3, 0, 1'b0);
		push_item(OP_ADD, 3, -1, 1'b0);
		push_item(OP_READ, 3, 0, 1'b0);
		push_item(OP_NOP, 1, 127, 1'b0);
		push_item(OP_READ, 1, 0, 1'b0);
		push_item(OP_CLEAR, 0, 0, 1'b1);
		push_item(OP_READ, 4095, 0, 1'b0);
		push_item(OP_READ, 1, 0, 1'b0);
		push_item(OP_ADD, 2048, 64, 1'b0);
		push_item(OP_READ, 2048, 0, 1'b0);

		// random: cells concentrate on a small label pool so reads see real fractions
		n = 0;
		pool_age = 0;
		clears = 0;
		first = 1'b1;
		while (n < 1800) begin
			if (pool_age == 0) begin
				foreach (pool[i]) begin
					pool[i] = LABEL_BITS'($urandom_range(0, 4095));
					bias[i] = $urandom_range(0, 100);
				end
				if ($urandom_range(0, 1) == 0)
					pool[0] = '0;
				if ($urandom_range(0, 1) == 0)
					pool[1] = '1;
				pool_age = 200;
			end
			r = $urandom_range(0, 999);
			slot = $urandom_range(0, 7);
			if (r < 3 && clears < 6) begin
				push_item(OP_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 255), 1'b1);
				clears++;
			end else if (r < 23) begin
				push_item(OP_NOP, $urandom_range(0, 4095), $urandom_range(0, 255), first);
				first = 1'b0;
				continue;
			end else if (r < 123) begin
				lbl = ($urandom_range(0, 99) < 85) ? int'(pool[slot]) : $urandom_range(0, 4095);
				push_item(OP_READ, lbl, $urandom_range(0, 255), first);
			end else begin
				lbl = ($urandom_range(0, 99) < 95) ? int'(pool[slot]) : $urandom_range(0, 4095);
				if ($urandom_range(0, 7) == 0)
					nd = $urandom_range(0, 255);
				else if ($urandom_range(0, 99) < bias[slot])
					nd = $urandom_range(1, 127);
				else
					nd = -int'($urandom_range(0, 128));
				push_item(OP_ADD, lbl, nd, first);
			end
			first = 1'b0;
			n++;
			pool_age--;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || cells_ch.valid || fraction_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
